### rtl/core/rrw_pkg.sv
`timescale 1ns / 1ps

package rrw_pkg;

  localparam int RING = 12;
  localparam int RW   = 16;
  localparam int IDXW = 4;

  // Square root of three, Q30, rounded down.
  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

  localparam logic [15:0] STEP_Q7    = 16'd3840;
  localparam logic [15:0] FULL_Q7    = 16'd46080;
  localparam logic [15:0] QUARTER_Q7 = 16'd11520;

  localparam int CORDIC_STEPS = 17;
  localparam int CW = 44;  // CORDIC x and y width, signed
  localparam int ZW = 24;  // CORDIC angle width, signed Q16 degrees

  typedef logic [RW-1:0]   range_t;
  typedef logic [IDXW-1:0] idx_t;

  localparam idx_t LAST_IDX = idx_t'(RING - 1);

  typedef struct packed {
    idx_t first;
    idx_t second;
    logic degen;
  } rrw_tag_t;

  function automatic idx_t ring_left(input idx_t i);
    return (i == '0) ? LAST_IDX : idx_t'(i - 1'b1);
  endfunction

  function automatic idx_t ring_right(input idx_t i);
    return (i == LAST_IDX) ? '0 : idx_t'(i + 1'b1);
  endfunction

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 24'sd2949120;
      1:       v = 24'sd1740967;
      2:       v = 24'sd919879;
      3:       v = 24'sd466945;
      4:       v = 24'sd234379;
      5:       v = 24'sd117304;
      6:       v = 24'sd58666;
      7:       v = 24'sd29335;
      8:       v = 24'sd14668;
      9:       v = 24'sd7334;
      10:      v = 24'sd3667;
      11:      v = 24'sd1833;
      12:      v = 24'sd917;
      13:      v = 24'sd458;
      14:      v = 24'sd229;
      15:      v = 24'sd115;
      16:      v = 24'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Shift of a signed value that truncates the magnitude toward zero.
  function automatic logic signed [CW-1:0] sshr(input logic signed [CW-1:0] v,
                                                input int unsigned s);
    logic [CW-1:0] mag;
    logic [CW-1:0] sh;
    mag = v[CW-1] ? (~v + 1'b1) : v;
    sh  = mag >> s;
    return v[CW-1] ? $signed(~sh + 1'b1) : $signed(sh);
  endfunction

endpackage

### rtl/core/rrw_isqrt.sv
`timescale 1ns / 1ps

// Integer square root, one result bit per stage, with a sideband carried alongside.
module rrw_isqrt #(
  parameter int NW  = 64,
  parameter int SBW = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     rad_in,
  input  logic [SBW-1:0]    sb_in,
  output logic [NW/2-1:0]   root_out,
  output logic [SBW-1:0]    sb_out
);
  localparam int RTW  = NW / 2;
  localparam int REMW = RTW + 3;

  logic [NW-1:0]   rad_r  [RTW-1];
  logic [REMW-1:0] rem_r  [RTW-1];
  logic [RTW-1:0]  root_r [RTW];
  logic [SBW-1:0]  sb_r   [RTW];

  logic [NW-1:0]   rad_p  [RTW];
  logic [REMW-1:0] rem_p  [RTW];
  logic [RTW-1:0]  root_p [RTW];
  logic [SBW-1:0]  sb_p   [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rad_p[k]  = rad_in;
      assign rem_p[k]  = '0;
      assign root_p[k] = '0;
      assign sb_p[k]   = sb_in;
    end else begin : g_next
      assign rad_p[k]  = rad_r[k-1];
      assign rem_p[k]  = rem_r[k-1];
      assign root_p[k] = root_r[k-1];
      assign sb_p[k]   = sb_r[k-1];
    end

    assign rem_sh = {rem_p[k][REMW-3:0], rad_p[k][NW-1-2*k -: 2]};
    assign trial  = {1'b0, root_p[k], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_p[k][RTW-2:0], take};
        sb_r[k]   <= sb_p[k];
      end
    end

    if (k < RTW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k] <= rad_p[k];
          rem_r[k] <= take ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign root_out = root_r[RTW-1];
  assign sb_out   = sb_r[RTW-1];

endmodule

### rtl/core/rrw_cordic.sv
`timescale 1ns / 1ps

// CORDIC vectoring, one step per stage, giving the angle of (x, y) in Q16 degrees.
module rrw_cordic (
  input  logic                          clk,
  input  logic                          en,
  input  logic [23:0]                   x_in,
  input  logic [23:0]                   y_in,
  input  rrw_pkg::rrw_tag_t             tag_in,
  output logic signed [rrw_pkg::ZW-1:0] z_out,
  output rrw_pkg::rrw_tag_t             tag_out
);
  import rrw_pkg::*;

  logic signed [CW-1:0] x_r   [CORDIC_STEPS-1];
  logic signed [CW-1:0] y_r   [CORDIC_STEPS-1];
  logic signed [ZW-1:0] z_r   [CORDIC_STEPS];
  rrw_tag_t             tag_r [CORDIC_STEPS];

  logic signed [CW-1:0] x_p   [CORDIC_STEPS];
  logic signed [CW-1:0] y_p   [CORDIC_STEPS];
  logic signed [ZW-1:0] z_p   [CORDIC_STEPS];
  rrw_tag_t             tag_p [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 down;

    if (k == 0) begin : g_first
      assign x_p[k]   = $signed({{(CW-40){1'b0}}, x_in, 16'b0});
      assign y_p[k]   = $signed({{(CW-40){1'b0}}, y_in, 16'b0});
      assign z_p[k]   = '0;
      assign tag_p[k] = tag_in;
    end else begin : g_next
      assign x_p[k]   = x_r[k-1];
      assign y_p[k]   = y_r[k-1];
      assign z_p[k]   = z_r[k-1];
      assign tag_p[k] = tag_r[k-1];
    end

    assign dx   = sshr(y_p[k], k);
    assign dy   = sshr(x_p[k], k);
    assign down = (y_p[k] > 0);

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[k]   <= down ? (z_p[k] + atan_q16(k)) : (z_p[k] - atan_q16(k));
        tag_r[k] <= tag_p[k];
      end
    end

    if (k < CORDIC_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k] <= down ? (x_p[k] + dx) : (x_p[k] - dx);
          y_r[k] <= down ? (y_p[k] - dy) : (y_p[k] + dy);
        end
      end
    end
  end

  assign z_out   = z_r[CORDIC_STEPS-1];
  assign tag_out = tag_r[CORDIC_STEPS-1];

endmodule

### rtl/core/range_ring_wall_estimator_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_range_0 .. in_range_11
// out      output     out_valid / out_stall out_wall_distance, out_wall_angle,
//                                           out_first_index, out_second_index,
//                                           out_degenerate
//
// One scan is taken every cycle unless in_stall is high; its result follows the transfer.
// The pipeline runs through the two square roots (32 and 24 stages, one root bit each),
// the 25-stage quotient and the 17 CORDIC stages.
// All stages advance together; a held result freezes the pipeline, so in_stall
// follows out_valid and out_stall. Reset clears only the valid bits.
module range_ring_wall_estimator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rrw_pkg::range_t     in_range_0,
  input  rrw_pkg::range_t     in_range_1,
  input  rrw_pkg::range_t     in_range_2,
  input  rrw_pkg::range_t     in_range_3,
  input  rrw_pkg::range_t     in_range_4,
  input  rrw_pkg::range_t     in_range_5,
  input  rrw_pkg::range_t     in_range_6,
  input  rrw_pkg::range_t     in_range_7,
  input  rrw_pkg::range_t     in_range_8,
  input  rrw_pkg::range_t     in_range_9,
  input  rrw_pkg::range_t     in_range_10,
  input  rrw_pkg::range_t     in_range_11,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         out_wall_distance,
  output logic [15:0]         out_wall_angle,
  output rrw_pkg::idx_t       out_first_index,
  output rrw_pkg::idx_t       out_second_index,
  output logic                out_degenerate
);
  import rrw_pkg::*;

  localparam int RT1 = 32;  // root bits of the third side
  localparam int QW  = 25;  // quotient bits of the height
  localparam int RT2 = 24;  // root bits of the opposite leg
  localparam int LAT = 7 + RT1 + 1 + QW + 1 + 2 + RT2 + CORDIC_STEPS + 1;

  typedef struct packed {
    logic [31:0] ab;
    range_t      a;
    rrw_tag_t    tag;
  } sq1_sb_t;

  typedef struct packed {
    logic [23:0] h;
    rrw_tag_t    tag;
  } sq2_sb_t;

  logic adv;
  logic [LAT-1:0] vld_r;

  range_t in_rng [RING];

  assign in_rng[0]  = in_range_0;
  assign in_rng[1]  = in_range_1;
  assign in_rng[2]  = in_range_2;
  assign in_rng[3]  = in_range_3;
  assign in_rng[4]  = in_range_4;
  assign in_rng[5]  = in_range_5;
  assign in_rng[6]  = in_range_6;
  assign in_rng[7]  = in_range_7;
  assign in_rng[8]  = in_range_8;
  assign in_rng[9]  = in_range_9;
  assign in_rng[10] = in_range_10;
  assign in_rng[11] = in_range_11;

  assign adv      = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Minimum search: 12 to 6, 6 to 3, 3 to 1. The lower index wins a tie.
  range_t rng1_r [RING];
  range_t w1v_r  [RING/2];
  idx_t   w1i_r  [RING/2];
  range_t rng2_r [RING];
  range_t w2v_r  [RING/4];
  idx_t   w2i_r  [RING/4];
  range_t rng3_r [RING];
  range_t mv3_r;
  idx_t   m3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < RING; i++) begin
        rng1_r[i] <= in_rng[i];
        rng2_r[i] <= rng1_r[i];
        rng3_r[i] <= rng2_r[i];
      end
      for (int i = 0; i < RING/2; i++) begin
        if (in_rng[2*i+1] < in_rng[2*i]) begin
          w1v_r[i] <= in_rng[2*i+1];
          w1i_r[i] <= idx_t'(2*i+1);
        end else begin
          w1v_r[i] <= in_rng[2*i];
          w1i_r[i] <= idx_t'(2*i);
        end
      end
      for (int i = 0; i < RING/4; i++) begin
        if (w1v_r[2*i+1] < w1v_r[2*i]) begin
          w2v_r[i] <= w1v_r[2*i+1];
          w2i_r[i] <= w1i_r[2*i+1];
        end else begin
          w2v_r[i] <= w1v_r[2*i];
          w2i_r[i] <= w1i_r[2*i];
        end
      end
    end
  end

  range_t mv3_nxt;
  idx_t   m3_nxt;

  always_comb begin
    mv3_nxt = w2v_r[0];
    m3_nxt  = w2i_r[0];
    if (w2v_r[1] < mv3_nxt) begin
      mv3_nxt = w2v_r[1];
      m3_nxt  = w2i_r[1];
    end
    if (w2v_r[2] < mv3_nxt) begin
      mv3_nxt = w2v_r[2];
      m3_nxt  = w2i_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mv3_r <= mv3_nxt;
      m3_r  <= m3_nxt;
    end
  end

  // Pair selection with the smaller neighbor; the right one wins a tie.
  range_t   rl;
  range_t   rr;
  range_t   a4_nxt;
  range_t   b4_nxt;
  rrw_tag_t tag4_nxt;
  range_t   a4_r;
  range_t   b4_r;
  rrw_tag_t tag4_r;

  always_comb begin
    rl = '0;
    rr = '0;
    for (int i = 0; i < RING; i++) begin
      if (ring_right(idx_t'(i)) == m3_r) rl = rng3_r[i];
      if (ring_left(idx_t'(i)) == m3_r) rr = rng3_r[i];
    end
    if (rl < rr) begin
      a4_nxt          = rl;
      b4_nxt          = mv3_r;
      tag4_nxt.first  = ring_left(m3_r);
      tag4_nxt.second = m3_r;
    end else begin
      a4_nxt          = mv3_r;
      b4_nxt          = rr;
      tag4_nxt.first  = m3_r;
      tag4_nxt.second = ring_right(m3_r);
    end
    tag4_nxt.degen = (a4_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_r   <= a4_nxt;
      b4_r   <= b4_nxt;
      tag4_r <= tag4_nxt;
    end
  end

  // Third side squared in Q30: (a^2 + b^2) * 2^30 - sqrt(3) * a * b.
  logic [31:0] aa5_r;
  logic [31:0] bb5_r;
  logic [31:0] ab5_r;
  range_t      a5_r;
  rrw_tag_t    tag5_r;
  logic [62:0] p6_r;
  logic [32:0] s6_r;
  logic [31:0] ab6_r;
  range_t      a6_r;
  rrw_tag_t    tag6_r;
  logic [62:0] c2_7_r;
  sq1_sb_t     sb7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      aa5_r  <= a4_r * a4_r;
      bb5_r  <= b4_r * b4_r;
      ab5_r  <= a4_r * b4_r;
      a5_r   <= a4_r;
      tag5_r <= tag4_r;

      p6_r   <= ab5_r * SQRT3_Q30;
      s6_r   <= {1'b0, aa5_r} + {1'b0, bb5_r};
      ab6_r  <= ab5_r;
      a6_r   <= a5_r;
      tag6_r <= tag5_r;

      c2_7_r    <= {s6_r, 30'b0} - p6_r;
      sb7_r.ab  <= ab6_r;
      sb7_r.a   <= a6_r;
      sb7_r.tag <= tag6_r;
    end
  end

  logic [RT1-1:0] cq;
  sq1_sb_t        sb_cq;

  rrw_isqrt #(
    .NW  (2 * RT1),
    .SBW ($bits(sq1_sb_t))
  ) u_isqrt_c (
    .clk      (clk),
    .en       (adv),
    .rad_in   ({1'b0, c2_7_r}),
    .sb_in    (sb7_r),
    .root_out (cq),
    .sb_out   (sb_cq)
  );

  // Height: (a*b*2^22 + cq/2) / cq. A quotient too wide for QW bits is above the cap.
  logic [54:0]    num;
  logic [31:0]    d0_rem_r;
  logic [31:0]    d0_cq_r;
  logic [QW-1:0]  d0_nlo_r;
  logic           d0_ovf_r;
  range_t         d0_a_r;
  rrw_tag_t       d0_tag_r;

  assign num = {1'b0, sb_cq.ab, 22'b0} + {24'b0, cq[31:1]};

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_rem_r <= {2'b0, num[54:QW]};
      d0_cq_r  <= cq;
      d0_nlo_r <= num[QW-1:0];
      d0_ovf_r <= ({2'b0, num[54:QW]} >= cq);
      d0_a_r   <= sb_cq.a;
      d0_tag_r <= sb_cq.tag;
    end
  end

  logic [31:0]   drem_r [QW-1];
  logic [31:0]   dcq_r  [QW-1];
  logic [QW-1:0] dnlo_r [QW-1];
  logic [QW-1:0] dq_r   [QW];
  logic          dovf_r [QW];
  range_t        da_r   [QW];
  rrw_tag_t      dtag_r [QW];

  logic [31:0]   drem_p [QW];
  logic [31:0]   dcq_p  [QW];
  logic [QW-1:0] dnlo_p [QW];
  logic [QW-1:0] dq_p   [QW];
  logic          dovf_p [QW];
  range_t        da_p   [QW];
  rrw_tag_t      dtag_p [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [32:0] rem_sh;
    logic        ge;

    if (j == 0) begin : g_first
      assign drem_p[j] = d0_rem_r;
      assign dcq_p[j]  = d0_cq_r;
      assign dnlo_p[j] = d0_nlo_r;
      assign dq_p[j]   = '0;
      assign dovf_p[j] = d0_ovf_r;
      assign da_p[j]   = d0_a_r;
      assign dtag_p[j] = d0_tag_r;
    end else begin : g_next
      assign drem_p[j] = drem_r[j-1];
      assign dcq_p[j]  = dcq_r[j-1];
      assign dnlo_p[j] = dnlo_r[j-1];
      assign dq_p[j]   = dq_r[j-1];
      assign dovf_p[j] = dovf_r[j-1];
      assign da_p[j]   = da_r[j-1];
      assign dtag_p[j] = dtag_r[j-1];
    end

    assign rem_sh = {drem_p[j], dnlo_p[j][QW-1-j]};
    assign ge     = (rem_sh >= {1'b0, dcq_p[j]});

    always_ff @(posedge clk) begin
      if (adv) begin
        dq_r[j]   <= {dq_p[j][QW-2:0], ge};
        dovf_r[j] <= dovf_p[j];
        da_r[j]   <= da_p[j];
        dtag_r[j] <= dtag_p[j];
      end
    end

    if (j < QW - 1) begin : g_carry
      logic [32:0] rem_nxt;
      assign rem_nxt = ge ? (rem_sh - {1'b0, dcq_p[j]}) : rem_sh;
      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[j] <= rem_nxt[31:0];
          dcq_r[j]  <= dcq_p[j];
          dnlo_r[j] <= dnlo_p[j];
        end
      end
    end
  end

  // Cap at a, then the opposite leg squared: (a*2^8)^2 - h^2.
  logic [23:0] aq8;
  logic [23:0] h66_r;
  range_t      a66_r;
  rrw_tag_t    tag66_r;
  logic [47:0] asq67_r;
  logic [47:0] hsq67_r;
  sq2_sb_t     sb67_r;
  logic [47:0] d68_r;
  sq2_sb_t     sb68_r;

  assign aq8 = {da_r[QW-1], 8'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dovf_r[QW-1] || (dq_r[QW-1] > {1'b0, aq8})) begin
        h66_r <= aq8;
      end else begin
        h66_r <= dq_r[QW-1][23:0];
      end
      a66_r   <= da_r[QW-1];
      tag66_r <= dtag_r[QW-1];

      asq67_r    <= {a66_r, 8'b0} * {a66_r, 8'b0};
      hsq67_r    <= h66_r * h66_r;
      sb67_r.h   <= h66_r;
      sb67_r.tag <= tag66_r;

      d68_r  <= asq67_r - hsq67_r;
      sb68_r <= sb67_r;
    end
  end

  logic [RT2-1:0] yq;
  sq2_sb_t        sb_y;

  rrw_isqrt #(
    .NW  (2 * RT2),
    .SBW ($bits(sq2_sb_t))
  ) u_isqrt_y (
    .clk      (clk),
    .en       (adv),
    .rad_in   (d68_r),
    .sb_in    (sb68_r),
    .root_out (yq),
    .sb_out   (sb_y)
  );

  logic signed [ZW-1:0] z_cor;
  rrw_tag_t             tag_cor;
  logic [23:0]          h_cor;
  logic [23:0]          h_dly_r [CORDIC_STEPS];

  rrw_cordic u_cordic (
    .clk     (clk),
    .en      (adv),
    .x_in    (sb_y.h),
    .y_in    (yq),
    .tag_in  (sb_y.tag),
    .z_out   (z_cor),
    .tag_out (tag_cor)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      h_dly_r[0] <= sb_y.h;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        h_dly_r[i] <= h_dly_r[i-1];
      end
    end
  end

  assign h_cor = h_dly_r[CORDIC_STEPS-1];

  // Angle: clamp at zero, round to Q7, cap at a quarter turn, add the sector, wrap.
  logic [ZW-2:0] zc;
  logic [ZW-1:0] zr;
  logic [15:0]   q7;
  logic [15:0]   ang;
  logic [15:0]   ang_nxt;

  always_comb begin
    zc  = z_cor[ZW-1] ? '0 : z_cor[ZW-2:0];
    zr  = {1'b0, zc} + 24'd256;
    q7  = {1'b0, zr[ZW-1:9]};
    if (q7 > QUARTER_Q7) q7 = QUARTER_Q7;
    ang = 16'(16'(tag_cor.first) * STEP_Q7) + q7;
    ang_nxt = (ang > FULL_Q7) ? (ang - FULL_Q7) : ang;
  end

  logic [23:0] dist_r;
  logic [15:0] ang_r;
  idx_t        first_r;
  idx_t        second_r;
  logic        degen_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      degen_r <= tag_cor.degen;
      if (tag_cor.degen) begin
        dist_r   <= '0;
        ang_r    <= '0;
        first_r  <= '0;
        second_r <= '0;
      end else begin
        dist_r   <= h_cor;
        ang_r    <= ang_nxt;
        first_r  <= tag_cor.first;
        second_r <= tag_cor.second;
      end
    end
  end

  assign out_valid         = vld_r[LAT-1];
  assign out_wall_distance = dist_r;
  assign out_wall_angle    = ang_r;
  assign out_first_index   = first_r;
  assign out_second_index  = second_r;
  assign out_degenerate    = degen_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_wall_distance == '0 && out_wall_angle == '0 &&
      out_first_index == '0 && out_second_index == '0)
    else $error("degenerate result carries nonzero fields");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> out_wall_angle <= FULL_Q7)
    else $error("wall angle beyond a full turn");

  a_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      (out_first_index < LAST_IDX && out_second_index == out_first_index + 4'd1) ||
      (out_first_index == LAST_IDX && out_second_index == '0))
    else $error("chosen pair is not two ring neighbors");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule

### verif/range_ring_wall_estimator_top_test.sv
`timescale 1ns / 1ps

module range_ring_wall_estimator_top_test;
  import rrw_pkg::*;

  typedef struct {
    logic [23:0] distance;
    logic [15:0] angle;
    idx_t        first;
    idx_t        second;
    logic        degen;
  } wall_est_t;

  // Predicts the wall estimate of every scan that enters the block and checks the
  // results against it in order.
  class wall_scoreboard;
    wall_est_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned degen_seen;

    static function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
        if (n >= res + bits) begin
          n = n - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
      return res;
    endfunction

    static function automatic longint shr_mag(input longint v, input int s);
      if (v >= 0) return longint'(64'(v) >> s);
      return -longint'(64'(-v) >> s);
    endfunction

    static function automatic logic [15:0] vector_angle(input logic [63:0] xq8,
                                                        input logic [63:0] yq8);
      longint atans[17];
      longint x, y, z, dx, dy;
      logic [63:0] q7;
      atans = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};
      x = longint'(xq8 << 16);
      y = longint'(yq8 << 16);
      z = 0;
      for (int i = 0; i < 17; i++) begin
        dx = shr_mag(y, i);
        dy = shr_mag(x, i);
        if (y > 0) begin
          x += dx; y -= dy; z += atans[i];
        end else begin
          x -= dx; y += dy; z -= atans[i];
        end
      end
      if (z < 0) z = 0;
      q7 = (64'(z) + 64'd256) >> 9;
      if (q7 > 64'(QUARTER_Q7)) q7 = 64'(QUARTER_Q7);
      return q7[15:0];
    endfunction

    function void note_scan(input range_t r[12]);
      wall_est_t e;
      int m, lft, rgt, fi, si;
      logic [63:0] a, b, c2, cq, h, aq8, y, ang;
      m = 0;
      for (int i = 1; i < 12; i++) if (r[i] < r[m]) m = i;
      lft = (m + 11) % 12;
      rgt = (m + 1) % 12;
      if (r[lft] < r[rgt]) begin
        fi = lft; si = m;
      end else begin
        fi = m; si = rgt;
      end
      a = r[fi];
      b = r[si];
      e = '{24'd0, 16'd0, 4'd0, 4'd0, 1'b1};
      if (a != 0) begin
        c2 = ((a * a) << 30) + ((b * b) << 30) - a * b * 64'd1859775393;
        cq = int_sqrt(c2);
        h = (((a * b) << 22) + (cq >> 1)) / cq;
        aq8 = a << 8;
        if (h > aq8) h = aq8;
        y = int_sqrt(aq8 * aq8 - h * h);
        ang = fi * 64'(STEP_Q7) + vector_angle(h, y);
        if (ang > 64'(FULL_Q7)) ang -= 64'(FULL_Q7);
        e = '{h[23:0], ang[15:0], idx_t'(fi), idx_t'(si), 1'b0};
      end
      pending.push_back(e);
    endfunction

    function void check_result(input wall_est_t got);
      wall_est_t e;
      if (pending.size() == 0) begin
        $error("result with no scan waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.degen) degen_seen++;
      if (got.distance !== e.distance) begin
        $error("wall_distance: expected %0d, got %0d", e.distance, got.distance); errors++;
      end
      if (got.angle !== e.angle) begin
        $error("wall_angle: expected %0d, got %0d", e.angle, got.angle); errors++;
      end
      if (got.first !== e.first) begin
        $error("first_index: expected %0d, got %0d", e.first, got.first); errors++;
      end
      if (got.second !== e.second) begin
        $error("second_index: expected %0d, got %0d", e.second, got.second); errors++;
      end
      if (got.degen !== e.degen) begin
        $error("degenerate: expected %0d, got %0d", e.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  range_t rng[12];
  logic [23:0] out_wall_distance;
  logic [15:0] out_wall_angle;
  idx_t out_first_index, out_second_index;
  logic out_degenerate;

  wall_scoreboard sb;
  bit hold_off;
  int unsigned scans_sent;

  range_ring_wall_estimator_top dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_range_0(rng[0]), .in_range_1(rng[1]), .in_range_2(rng[2]),
    .in_range_3(rng[3]), .in_range_4(rng[4]), .in_range_5(rng[5]),
    .in_range_6(rng[6]), .in_range_7(rng[7]), .in_range_8(rng[8]),
    .in_range_9(rng[9]), .in_range_10(rng[10]), .in_range_11(rng[11]),
    .out_valid, .out_stall, .out_wall_distance, .out_wall_angle,
    .out_first_index, .out_second_index, .out_degenerate
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Offers one scan, after a random gap unless no_gap is set, and holds it until the transfer.
  // Valid stays high across back-to-back scans; callers drop it when the stream pauses.
  task automatic send_scan(input range_t r[12], input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 12; i++) rng[i] <= r[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_scan(r);
    scans_sent++;
  endtask

  function automatic range_t rand_range(input int style);
    case (style)
      0: return range_t'($urandom);
      1: return range_t'($urandom_range(8));
      2: return range_t'(16'hffff - $urandom_range(3));
      default: return range_t'($urandom_range(4000, 100));
    endcase
  endfunction

  task automatic random_scan(input bit no_gap);
    range_t r[12];
    int style, m;
    style = $urandom_range(3);
    for (int i = 0; i < 12; i++) r[i] = rand_range(style);
    // Often plant a clear wall minimum, sometimes with tied neighbours.
    if ($urandom_range(2) == 0) begin
      m = $urandom_range(11);
      r[m] = range_t'($urandom_range(300));
      r[(m + 1) % 12] = range_t'(r[m] + $urandom_range(200));
      r[(m + 11) % 12] = $urandom_range(1) ? r[(m + 1) % 12] : range_t'(r[m] + 300);
      if ($urandom_range(9) == 0) r[(m + 1) % 12] = r[m];
    end
    send_scan(r, no_gap);
  endtask

  task automatic directed_scans();
    range_t r[12];
    for (int k = 0; k < 12; k++) begin
      // Minimum at each index in turn; alternate which neighbour is smaller.
      for (int i = 0; i < 12; i++) r[i] = 16'd1000;
      r[k] = 16'd200;
      if (k % 2) r[(k + 11) % 12] = 16'd300; else r[(k + 1) % 12] = 16'd300;
      send_scan(r, 1'b0);
    end
    r = '{default: 16'hffff};
    send_scan(r, 1'b0);                 // all maximum, ties everywhere
    r = '{default: 16'h0000};
    send_scan(r, 1'b0);                 // all zero: degenerate
    r = '{default: 16'd500}; r[11] = 16'd0;
    send_scan(r, 1'b0);                 // zero first reading
    r = '{default: 16'd500}; r[4] = 16'd0; r[3] = 16'd10;
    send_scan(r, 1'b0);                 // zero second reading
    r = '{default: 16'd500}; r[0] = 16'd5; r[11] = 16'd7;
    send_scan(r, 1'b0);                 // wraparound pair 11/0
    r = '{default: 16'hffff}; r[6] = 16'hfffe; r[7] = 16'hfffe;
    send_scan(r, 1'b0);                 // tie on the minimum
    r = '{default: 16'd9}; r[2] = 16'd1; r[1] = 16'd65535; r[3] = 16'd65535;
    send_scan(r, 1'b0);                 // narrow dip between large neighbours
  endtask

  // Result side: random stall per transfer, plus a long hold-off on request.
  initial begin
    int wait_cycles;
    out_stall <= 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      wait_cycles = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (wait_cycles > 0 || hold_off) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result('{out_wall_distance, out_wall_angle, out_first_index,
                        out_second_index, out_degenerate});
    end
  end

  initial begin
    hold_off = 1'b0;
    repeat (400) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    for (int i = 0; i < 12; i++) rng[i] <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_scans();
    for (int n = 0; n < 2000; n++) begin
      random_scan(n % 300 < 40);
      if (n == 1000) begin
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Sent %0d scans, checked %0d results (%0d degenerate).",
             scans_sent, sb.checked, sb.degen_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("range_ring_wall_estimator_top_test: done, clean");
    else
      $display("range_ring_wall_estimator_top_test: done, errors");
    $finish;
  end

  initial begin
    #4ms;
    $display("range_ring_wall_estimator_top_test: done, errors");
    $finish;
  end

endmodule

### range_ring_wall_estimator_top.f
rtl/core/rrw_pkg.sv
rtl/core/rrw_isqrt.sv
rtl/core/rrw_cordic.sv
rtl/core/range_ring_wall_estimator_top.sv
verif/range_ring_wall_estimator_top_test.sv
